// ===== src/lpm_pkg.sv =====
package lpm_pkg;

  typedef struct packed {
    logic        mode;
    logic [31:0] sample_us;
    logic [6:0]  percent;
  } lpm_in_t;

  typedef struct packed {
    logic [8:0]  sample_count;
    logic [31:0] minimum_us;
    logic [31:0] maximum_us;
    logic [31:0] average_us;
    logic [31:0] percentile_us;
    logic        dropped;
  } lpm_out_t;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam int unsigned SumW = 44;

  // x/100 as (x * PctRecip) >> PctShift, exact for x below 2^20
  localparam int unsigned PctRecip = 671089;
  localparam int unsigned PctShift = 26;

endpackage

// ===== src/lpm_div.sv =====
// Restoring divider: one quotient bit per cycle, quotient truncated to 32 bits.
module lpm_div
  import lpm_pkg::*;
#(
  parameter int unsigned CntW = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SumW-1:0]   dividend_i,
  input  logic [CntW-1:0]   divisor_i,
  output logic              done_o,
  output logic [31:0]       quot_o
);

  localparam int unsigned StepW = $clog2(SumW + 1);

  logic [SumW-1:0]  quo_q, quo_d;
  logic [CntW:0]    rem_q, rem_d;
  logic [CntW-1:0]  dvs_q, dvs_d;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW:0]    trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[CntW-1:0], quo_q[SumW-1]};
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      step_d = StepW'(SumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[SumW-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q[31:0];

endmodule

// ===== src/latency_percentile_monitor.sv =====
// Latency percentile monitor.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one beat per
// item: mode 0 inserts sample_us into an ascending store of CAPACITY
// entries, mode 1 asks for the sample at index round(percent*(count-1)/100)
// (percent clamped to 100). Every item answers with exactly one beat on the
// output channel (out_valid_o / out_stall_i / out_data_o): count, min, max,
// truncated average and, on query, the percentile sample.
// One item is worked on at a time. Every item does three store reads (min,
// max, percentile) and the sum/count division, one quotient bit per cycle
// over the 44-bit sum. An add first shifts larger entries up one slot,
// reading and then writing each entry moved, and then writes the sample
// into its place.
// The result sits in an output register; the input is taken again once
// the result register is free, so a stalled receiver holds one result and
// then back-pressures the input. Reset clears count and sum; the store
// memory needs no clearing since only written entries reach the result.
module latency_percentile_monitor
  import lpm_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  lpm_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output lpm_out_t out_data_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SRD   = 7'b0000010,
    S_SHIFT = 7'b0000100,
    S_RDMIN = 7'b0001000,
    S_RDMAX = 7'b0010000,
    S_RDPCT = 7'b0100000,
    S_DIV   = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  lpm_in_t          item_q, item_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [CntW-1:0]  pos_q, pos_d;
  logic [31:0]      min_q, min_d, max_q, max_d, pct_q, pct_d;
  logic             drop_q, drop_d;
  logic             ovalid_q, ovalid_d;
  lpm_out_t         odata_q, odata_d;

  // store memory
  logic [31:0]      mem [CAPACITY];
  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [31:0]      wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // divider
  logic        div_start, div_done;
  logic [31:0] div_quot;

  lpm_div #(.CntW(CntW)) u_div (
    .clk_i, .rst_ni,
    .start_i   (div_start),
    .dividend_i(sum_q),
    .divisor_i (cnt_q),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // percentile index: (p*(n-1)+50)/100, n-1 below 4096
  // product registered, then divided by reciprocal multiply in S_RDPCT
  logic [6:0]       pclamp;
  logic [19:0]      pprod, pprod_q;
  logic [39:0]      pmul;
  logic [AddrW-1:0] pidx;
  logic [CntW-1:0]  nm1;
  always_comb begin
    pclamp = (item_q.percent > 7'd100) ? 7'd100 : item_q.percent;
    nm1    = cnt_q - 1'b1;
    pprod  = 20'(pclamp) * 20'(nm1) + 20'd50;
    pmul   = 40'(pprod_q) * 40'(PctRecip);
    pidx   = AddrW'(pmul >> PctShift);
  end

  wire accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE) || ovalid_q;

  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    pos_d     = pos_q;
    min_d     = min_q;
    max_d     = max_q;
    pct_d     = pct_q;
    drop_d    = drop_q;
    ovalid_d  = ovalid_q;
    odata_d   = odata_q;
    we        = 1'b0;
    waddr     = pos_q[AddrW-1:0];
    wdata     = item_q.sample_us;
    raddr     = '0;
    div_start = 1'b0;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_d = in_data_i;
          drop_d = 1'b0;
          pct_d  = '0;
          pos_d  = cnt_q;
          if (in_data_i.mode == MODE_ADD && cnt_q == CntW'(CAPACITY)) begin
            drop_d  = 1'b1;
            state_d = S_RDMIN;
          end else if (in_data_i.mode == MODE_ADD) begin
            state_d = S_SRD;
          end else begin
            state_d = S_RDMIN;
          end
        end
      end
      // read entry below insertion point, or write the sample at slot 0
      S_SRD: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          sum_d   = sum_q + SumW'(item_q.sample_us);
          state_d = S_RDMIN;
        end else begin
          raddr   = AddrW'(pos_q - 1'b1);
          state_d = S_SHIFT;
        end
      end
      // move larger entry up, or drop the sample in place
      S_SHIFT: begin
        we = 1'b1;
        if (rdata_q > item_q.sample_us) begin
          wdata   = rdata_q;
          pos_d   = pos_q - 1'b1;
          state_d = S_SRD;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          sum_d   = sum_q + SumW'(item_q.sample_us);
          state_d = S_RDMIN;
        end
      end
      S_RDMIN: begin
        raddr   = '0;
        state_d = S_RDMAX;
      end
      S_RDMAX: begin
        min_d   = rdata_q;
        raddr   = AddrW'(cnt_q - 1'b1);
        state_d = S_RDPCT;
      end
      S_RDPCT: begin
        max_d     = rdata_q;
        raddr     = pidx;
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (item_q.mode == MODE_QUERY && pos_q == '0) pct_d = rdata_q;
        pos_d = '1;
        if (div_done) begin
          ovalid_d = 1'b1;
          odata_d.sample_count  = 9'(cnt_q);
          odata_d.dropped       = drop_q;
          if (cnt_q == '0) begin
            odata_d.minimum_us    = '0;
            odata_d.maximum_us    = '0;
            odata_d.average_us    = '0;
            odata_d.percentile_us = '0;
          end else begin
            odata_d.minimum_us    = min_q;
            odata_d.maximum_us    = max_q;
            odata_d.average_us    = div_quot;
            odata_d.percentile_us = pct_q;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // pos_q is zeroed on entry to S_DIV so pct captures only once
    if (state_q == S_RDPCT) pos_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      sum_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      sum_q    <= sum_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    pos_q   <= pos_d;
    min_q   <= min_d;
    max_q   <= max_d;
    pct_q   <= pct_d;
    drop_q  <= drop_d;
    odata_q <= odata_d;
    pprod_q <= pprod;
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

endmodule

// ===== src/lpm_checker.sv =====
module lpm_checker
  import lpm_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input lpm_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input lpm_out_t out_data_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // an accepted item never yields a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("result too early");

  // no input taken while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken with result pending");

  // empty store reports zero minimum and average
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.sample_count == 9'd0 |->
      out_data_o.minimum_us == 32'd0 && out_data_o.average_us == 32'd0)
    else $error("nonzero stats on empty store");

  // min never exceeds max
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.minimum_us <= out_data_o.maximum_us)
    else $error("min above max");

endmodule

bind latency_percentile_monitor lpm_checker u_lpm_checker (.*);
